// ===== hdl/sud_pkg.sv =====
// Shared constants and types for the 64-bit signed/unsigned divider.
`default_nettype none

package sud_pkg;

    // Fixed port widths
    localparam int PORT_WIDTH   = 64;
    localparam int ACTION_WIDTH = 2;

    // Default operand width inside the divider
    localparam int DATA_WIDTH   = 64;

    // Action codes
    localparam logic [ACTION_WIDTH-1:0] ACT_SIGNED_QUO   = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_SIGNED_REM   = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_UNSIGNED_QUO = 2'd2;
    localparam logic [ACTION_WIDTH-1:0] ACT_UNSIGNED_REM = 2'd3;

    // Status of the iterative divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sud_core.sv =====
// Iterative restoring divide unit: one quotient bit per cycle.
`default_nettype none

module sud_core #(
    parameter int DATA_WIDTH = sud_pkg::DATA_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] numer,
    input  wire logic [DATA_WIDTH-1:0] denom,
    output logic      [DATA_WIDTH-1:0] quotient,
    output logic      [DATA_WIDTH-1:0] remainder,
    output sud_pkg::core_stat_t        stat
);

    localparam int CNT_WIDTH = $clog2(DATA_WIDTH);
    localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(DATA_WIDTH - 1);

    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] den_reg, den_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  take;

    // shift in the next dividend bit; the top bit is the carry out of rem
    assign shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign take    = ~diff[DATA_WIDTH];

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = numer;
            den_next  = denom;
            cnt_next  = LAST_STEP;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            quo_next = {quo_reg[DATA_WIDTH-2:0], take};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== hdl/signed_unsigned_divider_64.sv =====
// Top level of the signed/unsigned restoring divider with valid/ready channels.
// Sequence: an accepted input beat goes through the start, wait and fixup states to
//   the result beat; a zero divisor skips the divide loop and goes straight to fixup.
// One item at a time: the single shared shift-and-subtract unit forms one quotient
//   bit per cycle, and s_ready stays low until the result is written; a result held
//   by m_ready low keeps the block in fixup and delays the next input beat.
// Reset: synchronous, active low; clears the sequencer and the output valid.
`default_nettype none

module signed_unsigned_divider_64 #(
    parameter int DATA_WIDTH = sud_pkg::DATA_WIDTH
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [sud_pkg::ACTION_WIDTH-1:0]   s_action,
    input  wire logic [sud_pkg::PORT_WIDTH-1:0]     s_dividend,
    input  wire logic [sud_pkg::PORT_WIDTH-1:0]     s_divisor,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic      [sud_pkg::PORT_WIDTH-1:0]     m_result,
    output logic                                    m_divide_by_zero
);

    // Sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_FIX   = 2'd3;

    logic [1:0] state_reg, state_next;

    // Captured item
    logic [sud_pkg::ACTION_WIDTH-1:0] act_reg, act_next;
    logic [DATA_WIDTH-1:0]            mag_a_reg, mag_a_next;
    logic [DATA_WIDTH-1:0]            mag_b_reg, mag_b_next;
    logic                             a_neg_reg, a_neg_next;
    logic                             b_neg_reg, b_neg_next;
    logic                             dbz_reg, dbz_next;

    // Output register
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic                  flag_reg, flag_next;
    logic                  m_valid_reg, m_valid_next;

    // Operand views at the port
    logic [DATA_WIDTH-1:0] in_a, in_b;
    logic                  in_signed;
    logic                  in_a_neg, in_b_neg;

    // Divide unit
    logic                  core_start;
    logic [DATA_WIDTH-1:0] core_quo, core_rem;
    sud_pkg::core_stat_t   core_stat;

    // Sign fixup
    logic                  act_signed, act_quo;
    logic [DATA_WIDTH-1:0] raw_res;
    logic                  neg_res;
    logic [DATA_WIDTH-1:0] fix_res;

    logic in_beat, out_free;

    assign in_beat  = s_valid & s_ready;
    assign out_free = ~m_valid_reg | m_ready;

    // Bits above DATA_WIDTH are ignored
    assign in_a      = s_dividend[DATA_WIDTH-1:0];
    assign in_b      = s_divisor[DATA_WIDTH-1:0];
    assign in_signed = (s_action == sud_pkg::ACT_SIGNED_QUO) ||
                       (s_action == sud_pkg::ACT_SIGNED_REM);
    assign in_a_neg  = in_signed & in_a[DATA_WIDTH-1];
    assign in_b_neg  = in_signed & in_b[DATA_WIDTH-1];

    // Signed ops divide magnitudes, then fix the sign:
    // quotient negative when signs differ, remainder follows the dividend.
    assign act_signed = (act_reg == sud_pkg::ACT_SIGNED_QUO) ||
                        (act_reg == sud_pkg::ACT_SIGNED_REM);
    assign act_quo    = (act_reg == sud_pkg::ACT_SIGNED_QUO) ||
                        (act_reg == sud_pkg::ACT_UNSIGNED_QUO);
    assign raw_res    = act_quo ? core_quo : core_rem;
    assign neg_res    = act_signed & (act_quo ? (a_neg_reg ^ b_neg_reg) : a_neg_reg);
    assign fix_res    = dbz_reg ? '0 : (neg_res ? (~raw_res + 1'b1) : raw_res);

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        mag_a_next   = mag_a_reg;
        mag_b_next   = mag_b_reg;
        a_neg_next   = a_neg_reg;
        b_neg_next   = b_neg_reg;
        dbz_next     = dbz_reg;
        res_next     = res_reg;
        flag_next    = flag_reg;
        m_valid_next = m_valid_reg;
        core_start   = 1'b0;

        // drop the result once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    act_next   = s_action;
                    a_neg_next = in_a_neg;
                    b_neg_next = in_b_neg;
                    mag_a_next = in_a_neg ? (~in_a + 1'b1) : in_a;
                    mag_b_next = in_b_neg ? (~in_b + 1'b1) : in_b;
                    dbz_next   = (in_b == '0);
                    // a zero divisor needs no divide pass
                    state_next = (in_b == '0) ? S_FIX : S_START;
                end
            end
            S_START: begin
                core_start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (core_stat.done) begin
                    state_next = S_FIX;
                end
            end
            S_FIX: begin
                // hold here until the output register is free
                if (out_free) begin
                    res_next     = fix_res;
                    flag_next    = dbz_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        act_reg   <= act_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        a_neg_reg <= a_neg_next;
        b_neg_reg <= b_neg_next;
        dbz_reg   <= dbz_next;
        res_reg   <= res_next;
        flag_reg  <= flag_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    sud_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (core_start),
        .numer     (mag_a_reg),
        .denom     (mag_b_reg),
        .quotient  (core_quo),
        .remainder (core_rem),
        .stat      (core_stat)
    );

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_result         = sud_pkg::PORT_WIDTH'(res_reg);
    assign m_divide_by_zero = flag_reg;

    // An accepted beat either starts a divide or goes straight to fixup
    a_accept_path: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> (state_reg == S_START) || (state_reg == S_FIX))
        else $error("accepted beat did not advance the sequencer");

    // The divide unit only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.done |-> (state_reg == S_WAIT))
        else $error("divide unit finished outside the wait state");

    // The divide unit is idle whenever the block accepts input
    a_idle_core: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !core_stat.busy)
        else $error("divide unit busy while sequencer idle");

    // A divide-by-zero result is all zeros
    a_dbz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_divide_by_zero) |-> (m_result == '0))
        else $error("divide by zero gave a nonzero result");

endmodule

`default_nettype wire
